@@ src/http_chunked_body_decoder_top_macros.svh @@
// Assertion macros shared by the chunked body decoder modules.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define HCBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define HCBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hcbd_pkg.sv @@
// Types, codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps
package hcbd_pkg;

  localparam int SizeBitsDefault  = 32;
  localparam int TotalBitsDefault = 32;

  // Framing phases
  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SKIP_LF = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_TRAIL1  = 3'd3;
  localparam logic [2:0] PH_TRAIL2  = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  // Body modes
  localparam logic [2:0] MODE_IDENTITY = 3'd0;
  localparam logic [2:0] MODE_CHUNKED  = 3'd1;
  localparam logic [2:0] MODE_DEFLATE  = 3'd2;
  localparam logic [2:0] MODE_GZIP     = 3'd3;
  localparam logic [2:0] MODE_COMPRESS = 3'd4;

  // Completion status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_UNKNOWN     = 3'd2;
  localparam logic [2:0] ST_BAD_HEX     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic       new_body;
    logic       stream_end;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic        last_of_body;
    logic [2:0]  status;
    logic [31:0] body_total;
    logic [7:0]  payload_byte;
    logic        result_kind;
  } res_t;

  // Bit 4 marks a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = c - 8'd48;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'd97 && c <= 8'd102) begin
      v = c - 8'd87;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'd65 && c <= 8'd70) begin
      v = c - 8'd55;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

@@ src/hcbd_core.sv @@
// Framing state and per-byte decode of the chunked body decoder.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_top_macros.svh"
module hcbd_core #(
  parameter int SIZE_BITS  = hcbd_pkg::SizeBitsDefault,
  parameter int TOTAL_BITS = hcbd_pkg::TotalBitsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  hcbd_pkg::item_t item,
  input  logic [2:0]     body_mode,
  output logic           res_valid,
  output hcbd_pkg::res_t res
);
  import hcbd_pkg::*;

  localparam logic [TOTAL_BITS-1:0] TotMax = {TOTAL_BITS{1'b1}};

  logic [2:0]            phase, phase_next;
  logic [SIZE_BITS-1:0]  size_acc, size_acc_next;
  logic [SIZE_BITS-1:0]  remaining, remaining_next;
  logic [TOTAL_BITS-1:0] total, total_next;

  logic [2:0]            ph;
  logic [SIZE_BITS-1:0]  acc_e, rem_e, rem_dec;
  logic [TOTAL_BITS-1:0] tot_e;
  logic [4:0]            hd;
  logic                  fin, emit;
  logic [2:0]            fin_status;
  logic                  fin_zero_total;
  logic [63:0]           tot_wide;

  always_comb begin
    // new_body clears the state before the item is handled
    ph    = item.new_body ? PH_SIZE : phase;
    acc_e = item.new_body ? '0 : size_acc;
    rem_e = item.new_body ? '0 : remaining;
    tot_e = item.new_body ? '0 : total;
    rem_dec = rem_e - SIZE_BITS'(1);
    hd = hex_digit(item.in_byte);

    phase_next     = ph;
    size_acc_next  = acc_e;
    remaining_next = rem_e;
    total_next     = tot_e;
    fin            = 1'b0;
    emit           = 1'b0;
    fin_status     = ST_OK;
    fin_zero_total = 1'b0;

    if (ph != PH_DONE) begin
      if (body_mode == MODE_IDENTITY) begin
        if (item.stream_end) begin
          fin = 1'b1;
        end else begin
          emit = 1'b1;
          total_next = (tot_e == TotMax) ? TotMax : tot_e + TOTAL_BITS'(1);
        end
      end else if (body_mode == MODE_DEFLATE || body_mode == MODE_GZIP ||
                   body_mode == MODE_COMPRESS) begin
        fin = 1'b1;
        fin_status = ST_UNSUPPORTED;
        fin_zero_total = 1'b1;
      end else if (body_mode != MODE_CHUNKED) begin
        fin = 1'b1;
        fin_status = ST_UNKNOWN;
        fin_zero_total = 1'b1;
      end else if (item.stream_end) begin
        fin = 1'b1;
        fin_status = ST_TRUNCATED;
      end else begin
        unique case (ph)
          PH_SIZE: begin
            if (item.in_byte == CHAR_CR) begin
              phase_next = PH_SKIP_LF;
            end else if (!hd[4]) begin
              fin = 1'b1;
              fin_status = ST_BAD_HEX;
            end else if (acc_e[SIZE_BITS-1 -: 4] != 4'd0) begin
              fin = 1'b1;
              fin_status = ST_OVERFLOW;
            end else begin
              size_acc_next = {acc_e[SIZE_BITS-5:0], hd[3:0]};
            end
          end
          PH_SKIP_LF: begin
            if (acc_e == '0) begin
              fin = 1'b1;
            end else begin
              remaining_next = acc_e;
              size_acc_next  = '0;
              phase_next     = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_next = rem_dec;
            if (rem_dec == '0) phase_next = PH_TRAIL1;
            emit = 1'b1;
            total_next = (tot_e == TotMax) ? TotMax : tot_e + TOTAL_BITS'(1);
          end
          PH_TRAIL1: phase_next = PH_TRAIL2;
          PH_TRAIL2: begin
            total_next = (tot_e >= TotMax - TOTAL_BITS'(1)) ? TotMax
                                                          : tot_e + TOTAL_BITS'(2);
            phase_next = PH_SIZE;
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end

    if (fin) phase_next = PH_DONE;

    // Saturate the reported total to 32 bits
    tot_wide = fin_zero_total ? 64'd0 : 64'(tot_e);

    res_valid = fin || emit;
    res = '0;
    if (fin) begin
      res.result_kind  = 1'b1;
      res.last_of_body = 1'b1;
      res.status       = fin_status;
      res.body_total   = (|tot_wide[63:32]) ? 32'hFFFF_FFFF : tot_wide[31:0];
    end else if (emit) begin
      res.payload_byte = item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIZE;
      size_acc  <= '0;
      remaining <= '0;
      total     <= '0;
    end else if (step) begin
      phase     <= phase_next;
      size_acc  <= size_acc_next;
      remaining <= remaining_next;
      total     <= total_next;
    end
  end

  `HCBD_ASSERT_IMP(a_data_nonzero, phase == PH_DATA, remaining != '0,
                   "data phase with no bytes remaining")
  `HCBD_ASSERT_NXT(a_fin_done, step && fin, phase == PH_DONE,
                   "completion did not close the body")
  `HCBD_ASSERT_IMP(a_done_silent, step && !item.new_body && phase == PH_DONE, !res_valid,
                   "result produced after body completion")

endmodule

@@ src/http_chunked_body_decoder_top.sv @@
// Top level of the HTTP chunked body decoder: stream ports, input and result registers.
`timescale 1ns / 1ps
// A request waits in the input register; any result of it waits in the result register.
// Throughput: one byte per cycle unless stalled; the framing state updates once per byte.
// A stalled master side holds the result register, and one more request waits in
// the input register. Reset (rst, synchronous) empties both registers, sets the
// framing to size-line parsing with zero counts, and sets body_mode to chunked.
`include "http_chunked_body_decoder_top_macros.svh"
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS  = hcbd_pkg::SizeBitsDefault,
  parameter int TOTAL_BITS = hcbd_pkg::TotalBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic [1:0]  s_axis_tuser,   // stream_end, new_body
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload_byte, body_total, status, zero fill
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last_of_body
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data        // body_mode
);
  import hcbd_pkg::*;

  logic [2:0] body_mode;
  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  res_t       out_res;
  logic       out_free, step, core_valid;
  res_t       core_res;

  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mode <= MODE_CHUNKED;
    end else if (cfg_valid && cfg_ready) begin
      body_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= '{new_body: s_axis_tuser[1], stream_end: s_axis_tuser[0],
                   in_byte: s_axis_tdata};
    end
  end

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS),
    .TOTAL_BITS(TOTAL_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_item),
    .body_mode(body_mode),
    .res_valid(core_valid),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.status, out_res.body_total, out_res.payload_byte};
  assign m_axis_tuser  = out_res.result_kind;
  assign m_axis_tlast  = out_res.last_of_body;

  `HCBD_ASSERT_IMP(a_stall_full, !s_axis_tready, in_valid && out_valid && !m_axis_tready,
                   "input stalled without a full pipeline")
  `HCBD_ASSERT_IMP(a_payload_clean, out_valid && !out_res.result_kind,
                   out_res.status == ST_OK && out_res.body_total == 32'd0 &&
                   !out_res.last_of_body,
                   "payload request carries completion fields")
  `HCBD_ASSERT_IMP(a_kind_last, out_valid && out_res.result_kind, out_res.last_of_body,
                   "completion without last_of_body")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the HTTP chunked body decoder top level.
`timescale 1ns / 1ps
module tb;
  import hcbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [7:0] CHR_CR = CHAR_CR;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;
  localparam logic [7:0] CHR_UA = 8'h41;
  localparam logic [7:0] CHR_UF = 8'h46;
  localparam logic [7:0] CHR_LA = 8'h61;
  localparam logic [7:0] CHR_LF_HEX = 8'h66;
  localparam logic [7:0] CHR_SEMI = 8'h3B;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = MODE_CHUNKED;

  http_chunked_body_decoder_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  item_t pending_requests[$];
  item_t drive_req;
  res_t expected_results[$];
  logic [7:0] body_bytes[$];
  int requests_queued = 0;
  int requests_accepted = 0;
  int requests_counted = 0;
  int failures = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  // Decoder state as predicted from accepted requests
  logic [2:0] dec_mode;
  logic [2:0] dec_phase;
  logic [31:0] size_acc;
  logic [31:0] left_in_chunk;
  logic [31:0] byte_total;

  function automatic logic [31:0] add_sat(input logic [31:0] t, input logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, t} + {1'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) d = c - CHR_ZERO;
    else if (c >= CHR_LA && c <= CHR_LF_HEX) d = c - CHR_LA + 8'd10;
    else if (c >= CHR_UA && c <= CHR_UF) d = c - CHR_UA + 8'd10;
    else begin
      v = 4'd0;
      return 1'b0;
    end
    v = d[3:0];
    return 1'b1;
  endfunction

  function automatic void clear_decoder();
    dec_phase = PH_SIZE;
    size_acc = '0;
    left_in_chunk = '0;
    byte_total = '0;
  endfunction

  function automatic void emit_payload(input logic [7:0] b);
    res_t r;
    r = '0;
    r.payload_byte = b;
    expected_results.push_back(r);
  endfunction

  function automatic void finish_body(input logic [2:0] st, input logic [31:0] total);
    res_t r;
    r = '0;
    r.result_kind = 1'b1;
    r.body_total = total;
    r.status = st;
    r.last_of_body = 1'b1;
    dec_phase = PH_DONE;
    expected_results.push_back(r);
  endfunction

  function automatic void decode_request(input logic [7:0] b, input logic se, input logic nb);
    logic [3:0] nib;
    if (nb) clear_decoder();
    if (dec_phase == PH_DONE) return;
    if (dec_mode == MODE_IDENTITY) begin
      if (se) begin
        finish_body(ST_OK, byte_total);
      end else begin
        byte_total = add_sat(byte_total, 32'd1);
        emit_payload(b);
      end
      return;
    end
    if (dec_mode inside {MODE_DEFLATE, MODE_GZIP, MODE_COMPRESS}) begin
      finish_body(ST_UNSUPPORTED, '0);
      return;
    end
    if (dec_mode != MODE_CHUNKED) begin
      finish_body(ST_UNKNOWN, '0);
      return;
    end
    if (se) begin
      finish_body(ST_TRUNCATED, byte_total);
      return;
    end
    case (dec_phase)
      PH_SIZE: begin
        if (b == CHR_CR) dec_phase = PH_SKIP_LF;
        else if (!hex_nibble(b, nib)) finish_body(ST_BAD_HEX, byte_total);
        else if (size_acc[31:28] != 4'd0) finish_body(ST_OVERFLOW, byte_total);
        else size_acc = {size_acc[27:0], nib};
      end
      PH_SKIP_LF: begin
        if (size_acc == '0) begin
          finish_body(ST_OK, byte_total);
        end else begin
          left_in_chunk = size_acc;
          size_acc = '0;
          dec_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        left_in_chunk = left_in_chunk - 32'd1;
        if (left_in_chunk == '0) dec_phase = PH_TRAIL1;
        byte_total = add_sat(byte_total, 32'd1);
        emit_payload(b);
      end
      PH_TRAIL1: dec_phase = PH_TRAIL2;
      PH_TRAIL2: begin
        byte_total = add_sat(byte_total, 32'd2);
        dec_phase = PH_SIZE;
      end
      default: dec_phase = PH_DONE;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // Request driver: hold the request until it is taken, idle now and then
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        drive_req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= drive_req.in_byte;
        s_axis_tuser <= {drive_req.new_body, drive_req.stream_end};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      m_axis_tready <= 1'b0;
      stall_left <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Monitor: track mode writes, predict on every accepted request, check results
  always @(posedge clk) begin
    if (rst) begin
      dec_mode = MODE_CHUNKED;
      clear_decoder();
    end else begin
      if (cfg_valid && cfg_ready) dec_mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_request(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
        requests_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: tdata 0x%0h kind %0b",
                 m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          check_field("result_kind", 32'(expected_results[0].result_kind),
                      32'(m_axis_tuser));
          check_field("payload_byte", 32'(expected_results[0].payload_byte),
                      32'(m_axis_tdata[7:0]));
          check_field("body_total", expected_results[0].body_total, m_axis_tdata[39:8]);
          check_field("status", 32'(expected_results[0].status),
                      32'(m_axis_tdata[42:40]));
          check_field("last_of_body", 32'(expected_results[0].last_of_body),
                      32'(m_axis_tlast));
          void'(expected_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[http_chunked_body_decoder_top] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
    if (d < 4'd10) return CHR_ZERO + {4'h0, d};
    return (upper ? CHR_UA : CHR_LA) + {4'h0, d} - 8'd10;
  endfunction

  function automatic void queue_request(input logic [7:0] b, input logic se, input logic nb,
                                        input bit counted);
    item_t it;
    it.in_byte = b;
    it.stream_end = se;
    it.new_body = nb;
    pending_requests.push_back(it);
    requests_queued++;
    if (counted) requests_counted++;
  endfunction

  function automatic void add_size_line(input logic [31:0] n);
    int nd;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    if (n != 0 || $urandom_range(5) != 0) begin
      repeat ($urandom_range(2)) body_bytes.push_back(CHR_ZERO);
      for (int i = nd - 1; i >= 0; i--) body_bytes.push_back(hex_char(n[4*i +: 4],
                                                                      1'($urandom_range(1))));
    end
    body_bytes.push_back(CHR_CR);
    body_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : CHR_LF);
  endfunction

  // Chunked body with random content; a share of them broken on purpose
  function automatic void queue_chunked_body();
    int len;
    int flaw;
    bit cut_short;
    body_bytes.delete();
    cut_short = 1'b0;
    repeat ($urandom_range(3)) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_size_line(len);
      repeat (len) body_bytes.push_back(8'($urandom_range(255)));
      repeat (2) body_bytes.push_back(($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                               : (body_bytes.size() % 2 == 0
                                                                  ? CHR_CR : CHR_LF));
    end
    add_size_line(32'd0);
    flaw = $urandom_range(11);
    case (flaw)
      0: body_bytes[$urandom_range(body_bytes.size() - 1)] = 8'($urandom_range(255));
      1: begin
        len = $urandom_range(body_bytes.size() - 1);
        while (body_bytes.size() > len) void'(body_bytes.pop_back());
        cut_short = 1'b1;
      end
      2: begin
        // size line longer than the size register
        body_bytes.delete();
        body_bytes.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
        repeat (8 + $urandom_range(2))
          body_bytes.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      end
      3: body_bytes.insert(1, CHR_SEMI);
      default: ;
    endcase
    foreach (body_bytes[i]) queue_request(body_bytes[i], 1'b0, i == 0, 1'b1);
    if (cut_short) queue_request(8'($urandom_range(255)), 1'b1, body_bytes.size() == 0, 1'b1);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3))
        queue_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0);
    end
  endfunction

  function automatic void queue_identity_body();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) queue_request(8'($urandom_range(255)), 1'b0, i == 0, 1'b1);
    if ($urandom_range(4) != 0) queue_request(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
  endfunction

  task automatic write_mode(input logic [2:0] m);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every request to be taken and answered, then let the pipeline empty
  task automatic settle();
    while (requests_accepted != requests_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(MODE_CHUNKED);
    // one short well-formed body with extreme payload bytes, then a stray byte
    queue_request(hex_char(4'd2, 1'b0), 1'b0, 1'b1, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    queue_request(8'h00, 1'b0, 1'b0, 1'b1);
    queue_request(8'hFF, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    queue_request(hex_char(4'd0, 1'b0), 1'b0, 1'b0, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    queue_request(8'h78, 1'b0, 1'b0, 1'b0);
    // size overflow on the ninth digit, lower and upper case digits
    queue_request(hex_char(4'd15, 1'b0), 1'b0, 1'b1, 1'b1);
    repeat (7) queue_request(CHR_ZERO, 1'b0, 1'b0, 1'b1);
    queue_request(hex_char(4'd10, 1'b1), 1'b0, 1'b0, 1'b1);
    // bad hex digit, empty size line, truncated stream
    queue_request(8'h47, 1'b0, 1'b1, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b1, 1'b1);
    queue_request(8'h55, 1'b0, 1'b0, 1'b1);
    queue_request(hex_char(4'd1, 1'b0), 1'b0, 1'b1, 1'b1);
    queue_request(8'hA5, 1'b1, 1'b0, 1'b1);
    settle();

    // long stretch with no idling on either side
    calm = 1'b1;
    while (requests_counted < 180) queue_chunked_body();
    settle();
    calm = 1'b0;

    write_mode(MODE_IDENTITY);
    while (requests_counted < 300) queue_identity_body();
    hold_off_req = 1'b1;
    while (requests_counted < 340) queue_identity_body();
    settle();

    for (int m = MODE_DEFLATE; m <= 7; m++) begin
      write_mode(3'(m));
      repeat (3) begin
        queue_request(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b1, 1'b1);
        repeat (2)
          queue_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0);
      end
      settle();
    end

    // mode changes in the middle of a body keep phase and totals
    write_mode(MODE_CHUNKED);
    queue_request(hex_char(4'd5, 1'b0), 1'b0, 1'b1, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    repeat (2) queue_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    settle();
    write_mode(MODE_IDENTITY);
    repeat (3) queue_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    queue_request(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
    repeat (2) queue_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
    settle();
    write_mode(MODE_CHUNKED);
    queue_request(hex_char(4'd1, 1'b0), 1'b0, 1'b0, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    queue_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_ZERO, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_CR, 1'b0, 1'b0, 1'b1);
    queue_request(CHR_LF, 1'b0, 1'b0, 1'b1);
    settle();

    while (requests_counted < 600) queue_chunked_body();
    settle();

    if (failures == 0) begin
      $display("[http_chunked_body_decoder_top] OK");
    end else begin
      $display("[http_chunked_body_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
